// ===== rtl/cave_pkg.sv =====
// shared constants, codes and types of the cave automaton step block
// used by cave_cell, cave_ram and cave_cellular_automaton_step_top
package cave_pkg;

  // grid geometry
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int SIZE_W   = 7;
  localparam int LIM_W    = 4;
  localparam int CNT_W    = 4;

  // action codes of the input word
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_STEP  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // register indexes of the configuration port
  localparam logic [1:0] REG_DEATH = 2'd0;
  localparam logic [1:0] REG_BIRTH = 2'd1;
  localparam logic [1:0] REG_ROWS  = 2'd2;
  localparam logic [1:0] REG_COLS  = 2'd3;

  // control shared by every cell of the row
  typedef struct packed {
    logic              init;
    logic              shift;
    logic [LIM_W-1:0]  death;
    logic [LIM_W-1:0]  birth;
  } cell_ctl_t;

endpackage

// ===== rtl/cave_cell.sv =====
// one column cell: holds the rows above and at the current row of its column
// and computes the next value of its cell; depends on cave_pkg
module cave_cell (
  input  logic                  clk,
  input  cave_pkg::cell_ctl_t   ctl,
  input  logic                  din,        // incoming row bit (row below)
  input  logic                  active,     // column lies inside the region
  input  logic [2:0]            left_win,   // {below, mid, above} of left cell
  input  logic [2:0]            right_win,  // {below, mid, above} of right cell
  output logic [2:0]            win_out,    // own window, all live when inactive
  output logic                  new_bit,
  output logic                  changed
);

  logic                       up_r;
  logic                       mid_r;
  logic [cave_pkg::CNT_W-1:0] cnt;
  logic                       born;
  logic                       lives;

  // vertical window, shifted down by one row per sweep cycle
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      mid_r <= 1'b1;
    end else if (ctl.shift) begin
      up_r  <= mid_r;
      mid_r <= din;
    end
  end

  // window seen by the neighbours
  assign win_out = active ? {din, mid_r, up_r} : 3'b111;

  // live neighbour count of the moore window
  assign cnt = 4'(left_win[0]) + 4'(left_win[1]) + 4'(left_win[2])
             + 4'(right_win[0]) + 4'(right_win[1]) + 4'(right_win[2])
             + 4'(up_r) + 4'(din);

  // survival and birth rules
  assign lives = !(cnt < ctl.death);
  assign born  = cnt > ctl.birth;

  assign new_bit = active ? (mid_r ? lives : born) : mid_r;
  assign changed = active && (new_bit != mid_r);

endmodule

// ===== rtl/cave_ram.sv =====
// grid store: one row of cells per word, one write and one read port,
// registered read data; depends on cave_pkg
module cave_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [cave_pkg::ROW_W-1:0]    waddr,
  input  logic [cave_pkg::MAX_COLS-1:0] wdata,
  input  logic [cave_pkg::ROW_W-1:0]    raddr,
  output logic [cave_pkg::MAX_COLS-1:0] rdata
);

  logic [cave_pkg::MAX_COLS-1:0] mem [cave_pkg::MAX_ROWS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cave_cellular_automaton_step_top.sv =====
// top level of the cave automaton step block: control, registers, row of cells
// depends on cave_pkg, cave_cell and cave_ram
//
// Usage
//   in_* stream: one word per action (write cell, run one generation, read
//   cell). out_* stream: exactly one result word per input word, carrying
//   the read cell value and the converged flag after the action.
//   cfg_* apb port: death limit, birth limit, rows and columns in use; write
//   only while the block is idle.
// Sequence and throughput
//   write or read action: from acceptance through the cell and done states to
//   the result; an unused action goes straight to done. generation: a row
//   sweep through the single read port of the grid store (one row of 64
//   column cells per cycle), then a border pass when the grid converges.
//   one action is handled at a time; the next word is taken as soon as the
//   control returns to idle, even while the last result still waits.
// Reset
//   per-row valid flags clear at once, so the grid reads as all dead with
//   no clearing pass; registers return to 4, 4, 64, 64.
// Stall
//   a held result register keeps the block in its final state until the
//   receiver takes the word; nothing is lost or repeated.
module cave_cellular_automaton_step_top (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // action[1:0], row[7:2], col[13:8], cell_in[14], zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // cell_out[0], converged[1], zero
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CELL   = 5'b00010,
    ST_STEP   = 5'b00100,
    ST_BORDER = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t st_r, st_nxt;

  logic [cave_pkg::LIM_W-1:0]  death_r, birth_r;
  logic [cave_pkg::SIZE_W-1:0] rows_r, cols_r;
  logic [cave_pkg::SIZE_W-1:0] nr, nc;

  logic [1:0]                 act_r;
  logic [cave_pkg::ROW_W-1:0] row_r;
  logic [cave_pkg::COL_W-1:0] col_r;
  logic                       cell_r;

  logic [cave_pkg::SIZE_W-1:0] cnt_r, cnt_nxt;
  logic                        same_r, same_nxt;
  logic                        conv_r, conv_nxt;
  logic                        cell_out_r, cell_out_nxt;
  logic                        out_valid_r;
  logic [1:0]                  out_data_r;

  logic [cave_pkg::MAX_ROWS-1:0] rv_r;
  logic                          rv_hit_r;
  logic                          we;
  logic [cave_pkg::ROW_W-1:0]    waddr, raddr;
  logic [cave_pkg::MAX_COLS-1:0] wdata, rdata, row_val;

  logic [1:0]                 in_act;
  logic [cave_pkg::ROW_W-1:0] in_row;
  logic [cave_pkg::COL_W-1:0] in_col;
  logic                       in_cell;
  logic                       in_acc;
  logic                       out_free;
  logic                       cfg_wr;
  logic                       in_region;

  cave_pkg::cell_ctl_t           ctl;
  logic [cave_pkg::MAX_COLS-1:0] act_mask, edge_mask, col_mask;
  logic [cave_pkg::MAX_COLS-1:0] new_row, changed, din_row, border_row;
  logic [2:0]                    win [cave_pkg::MAX_COLS];
  logic [cave_pkg::SIZE_W-1:0]   wr_idx, bd_idx, nc_m1;
  logic                          is_edge;

  // input word fields
  assign in_act  = in_tdata[1:0];
  assign in_row  = in_tdata[7:2];
  assign in_col  = in_tdata[13:8];
  assign in_cell = in_tdata[14];

  assign in_tready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      death_r <= 4'd4;
      birth_r <= 4'd4;
      rows_r  <= 7'(cave_pkg::MAX_ROWS);
      cols_r  <= 7'(cave_pkg::MAX_COLS);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        cave_pkg::REG_DEATH: death_r <= cfg_pwdata[3:0];
        cave_pkg::REG_BIRTH: birth_r <= cfg_pwdata[3:0];
        cave_pkg::REG_ROWS:  rows_r  <= cfg_pwdata[6:0];
        cave_pkg::REG_COLS:  cols_r  <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      cave_pkg::REG_DEATH: cfg_prdata = 32'(death_r);
      cave_pkg::REG_BIRTH: cfg_prdata = 32'(birth_r);
      cave_pkg::REG_ROWS:  cfg_prdata = 32'(rows_r);
      cave_pkg::REG_COLS:  cfg_prdata = 32'(cols_r);
      default:             cfg_prdata = 32'd0;
    endcase
  end

  // region size, zero acts as one and large values as the maximum
  assign nr = (rows_r == 7'd0) ? 7'd1 :
              ((rows_r > 7'(cave_pkg::MAX_ROWS)) ? 7'(cave_pkg::MAX_ROWS) : rows_r);
  assign nc = (cols_r == 7'd0) ? 7'd1 :
              ((cols_r > 7'(cave_pkg::MAX_COLS)) ? 7'(cave_pkg::MAX_COLS) : cols_r);

  // latched input word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r  <= in_act;
      row_r  <= in_row;
      col_r  <= in_col;
      cell_r <= in_cell;
    end
  end

  // grid store and per-row valid flags
  cave_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= '0;
    end else if (we) begin
      rv_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rv_hit_r <= rv_r[raddr];
  end

  // a row never written reads as all dead
  assign row_val = rv_hit_r ? rdata : '0;

  // row of column cells
  assign ctl.init  = in_acc && (in_act == cave_pkg::ACT_STEP);
  assign ctl.shift = (st_r == ST_STEP) && (cnt_r != 7'd0);
  assign ctl.death = death_r;
  assign ctl.birth = birth_r;

  // rows beyond the region arrive as all live
  assign din_row = (cnt_r <= nr) ? row_val : '1;

  for (genvar c = 0; c < cave_pkg::MAX_COLS; c++) begin : g_cell
    logic [2:0] lw, rw;
    if (c == 0) begin : g_l
      assign lw = 3'b111;
    end else begin : g_l
      assign lw = win[c-1];
    end
    if (c == cave_pkg::MAX_COLS - 1) begin : g_r
      assign rw = 3'b111;
    end else begin : g_r
      assign rw = win[c+1];
    end
    assign act_mask[c] = nc > 7'(c);
    assign col_mask[c] = 1'b1;

    cave_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .din       (din_row[c]),
      .active    (act_mask[c]),
      .left_win  (lw),
      .right_win (rw),
      .win_out   (win[c]),
      .new_bit   (new_row[c]),
      .changed   (changed[c])
    );
  end

  // border forcing after convergence
  assign nc_m1      = nc - 7'd1;
  assign edge_mask  = (col_mask & 64'd1) | (64'd1 << nc_m1[cave_pkg::COL_W-1:0]);
  assign is_edge    = (cnt_r == 7'd1) || (cnt_r == nr);
  assign border_row = row_val | (is_edge ? act_mask : edge_mask);

  assign wr_idx    = cnt_r - 7'd2;
  assign bd_idx    = cnt_r - 7'd1;
  assign in_region = ({1'b0, row_r} < nr) && ({1'b0, col_r} < nc);

  // control sequencer
  always_comb begin
    st_nxt       = st_r;
    cnt_nxt      = cnt_r;
    same_nxt     = same_r;
    conv_nxt     = conv_r;
    cell_out_nxt = cell_out_r;
    we           = 1'b0;
    waddr        = row_r;
    wdata        = row_val;
    raddr        = in_row;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          cell_out_nxt = 1'b0;
          unique case (in_act)
            cave_pkg::ACT_WRITE, cave_pkg::ACT_READ: st_nxt = ST_CELL;
            cave_pkg::ACT_STEP: begin
              st_nxt   = ST_STEP;
              cnt_nxt  = 7'd0;
              same_nxt = 1'b1;
            end
            default: st_nxt = ST_DONE;
          endcase
        end
      end
      ST_CELL: begin
        if ((act_r == cave_pkg::ACT_WRITE) && in_region) begin
          we    = 1'b1;
          waddr = row_r;
          wdata = (row_val & ~(64'd1 << col_r)) | (64'(cell_r) << col_r);
        end
        if (act_r == cave_pkg::ACT_READ) begin
          cell_out_nxt = in_region && row_val[col_r];
        end
        st_nxt = ST_DONE;
      end
      ST_STEP: begin
        raddr   = cnt_r[cave_pkg::ROW_W-1:0];
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r >= 7'd2) begin
          we       = 1'b1;
          waddr    = wr_idx[cave_pkg::ROW_W-1:0];
          wdata    = new_row;
          same_nxt = same_r && !(|changed);
        end
        if (cnt_r == nr + 7'd1) begin
          conv_nxt = same_nxt;
          cnt_nxt  = 7'd0;
          st_nxt   = same_nxt ? ST_BORDER : ST_DONE;
        end
      end
      ST_BORDER: begin
        raddr   = cnt_r[cave_pkg::ROW_W-1:0];
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r != 7'd0) begin
          we    = 1'b1;
          waddr = bd_idx[cave_pkg::ROW_W-1:0];
          wdata = border_row;
        end
        if (cnt_r == nr) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      conv_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      conv_r <= conv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    same_r     <= same_nxt;
    cell_out_r <= cell_out_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((st_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((st_r == ST_DONE) && out_free) begin
      out_data_r <= {conv_r, cell_out_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};

endmodule
